@@ rtl/core/scba_pkg.sv @@
// Shared types, status codes and arena size table for the size class block allocator.
package scba_pkg;

  localparam int CLASS_W = 5;

  localparam logic [31:0] ARENA_BASE_RESET = 32'hC101_0000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_TOO_LARGE  = 3'd1;
  localparam logic [2:0] STS_OOM        = 3'd2;
  localparam logic [2:0] STS_MISALIGNED = 3'd3;
  localparam logic [2:0] STS_UNKNOWN    = 3'd4;
  localparam logic [2:0] STS_FULL       = 3'd5;

  typedef struct packed {
    logic        op;
    logic [31:0] request_size;
    logic [31:0] free_address;
  } alloc_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [31:0]        block_address;
    logic [CLASS_W-1:0] size_class;
  } alloc_rsp_t;

  // Arena size in bytes for each class; arenas sit back to back.
  function automatic logic [31:0] arena_bytes(input logic [CLASS_W-1:0] cls);
    logic [31:0] sz;
    unique case (cls)
      5'd0:    sz = 32'd131072;
      5'd1:    sz = 32'd262144;
      5'd2:    sz = 32'd524288;
      5'd3:    sz = 32'd1048576;
      5'd4:    sz = 32'd2097152;
      5'd5:    sz = 32'd4194304;
      5'd6:    sz = 32'd8388608;
      5'd7:    sz = 32'd16777216;
      5'd8:    sz = 32'd67108864;
      5'd9:    sz = 32'd8388608;
      5'd10:   sz = 32'd16777216;
      5'd11:   sz = 32'd131072;
      5'd12:   sz = 32'd262144;
      5'd13:   sz = 32'd524288;
      5'd14:   sz = 32'd1048576;
      5'd15:   sz = 32'd2097152;
      5'd16:   sz = 32'd4194304;
      5'd17:   sz = 32'd4194304;
      5'd18:   sz = 32'd8388608;
      5'd19:   sz = 32'd16777216;
      5'd20:   sz = 32'd33554432;
      default: sz = 32'd0;
    endcase
    return sz;
  endfunction

  // Block size of a class: 16 bytes shifted up by the class index.
  function automatic logic [31:0] block_bytes(input logic [CLASS_W-1:0] cls);
    return 32'd16 << cls;
  endfunction

endpackage

@@ rtl/core/size_class_block_allocator_top.sv @@
// Top level of the size class block allocator: class walker, free FIFOs and result register.
// Flow: an accepted item scans the classes from index 0 until its class (allocate) or arena (free)
// is found or the last class misses; an allocate that pops passes S_POP for the store read, and
// S_FINISH then loads the result into the output register. Throughput: one item at a time; the
// next is taken after a result enters the output register; a stalled output beat holds it back.
// Reset (rst, synchronous) clears offsets, FIFO pointers and counts and restores arena_base.
module size_class_block_allocator_top #(
  parameter int NUM_CLASSES = 21,
  parameter int FREE_DEPTH  = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  // Configuration: arena base address.
  input  logic                    cfg_wr_en,
  input  logic [31:0]             cfg_wr_data,
  // Request channel.
  input  logic                    in_valid,
  output logic                    in_stall,
  input  scba_pkg::alloc_req_t    in_data,
  // Response channel.
  output logic                    out_valid,
  input  logic                    out_stall,
  output scba_pkg::alloc_rsp_t    out_data
);

  localparam int ClsW      = scba_pkg::CLASS_W;
  localparam int CidxW     = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PtrW      = $clog2(FREE_DEPTH);
  localparam int CntW      = $clog2(FREE_DEPTH + 1);
  localparam int MemDepth  = NUM_CLASSES * FREE_DEPTH;
  localparam int MemAw     = $clog2(MemDepth);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_FINISH
  } state_t;

  state_t                 state;
  logic [31:0]            arena_base;
  scba_pkg::alloc_req_t   req;
  scba_pkg::alloc_rsp_t   res;
  logic [31:0]            start;
  logic [CidxW-1:0]       cls;

  // Per-class bookkeeping. Outside reset, each array is read and written only at the current class.
  logic [26:0]            bump_offset [NUM_CLASSES];
  logic [PtrW-1:0]        free_head   [NUM_CLASSES];
  logic [PtrW-1:0]        free_tail   [NUM_CLASSES];
  logic [CntW-1:0]        free_count  [NUM_CLASSES];

  // Freed addresses, one FIFO segment of FREE_DEPTH entries per class.
  logic [31:0]            free_store  [MemDepth];
  logic [31:0]            mem_rd_data;
  logic                   mem_rd_en;
  logic                   mem_wr_en;
  logic [MemAw-1:0]       mem_base;
  logic [MemAw-1:0]       mem_rd_addr;
  logic [MemAw-1:0]       mem_wr_addr;

  // Shared compare/add unit, evaluated for the current class on every scan cycle.
  logic [ClsW-1:0]        cls_ext;
  logic [31:0]            arena_sz;
  logic [31:0]            blk;
  logic [31:0]            rel;
  logic                   is_alloc;
  logic                   hit;
  logic                   last_cls;
  logic                   aligned;
  logic                   fifo_empty;
  logic                   fifo_full;
  logic [27:0]            bump_sum;
  logic                   bump_ok;
  logic [PtrW-1:0]        head_next;
  logic [PtrW-1:0]        tail_next;

  always_comb begin
    cls_ext    = ClsW'(cls);
    arena_sz   = scba_pkg::arena_bytes(cls_ext);
    blk        = scba_pkg::block_bytes(cls_ext);
    rel        = req.free_address - start;
    is_alloc   = (req.op == scba_pkg::OP_ALLOC);
    // An allocate stops at the first class that fits; a free at the arena holding it.
    hit        = is_alloc ? (req.request_size <= blk) : (rel < arena_sz);
    last_cls   = (cls == CidxW'(NUM_CLASSES - 1));
    aligned    = ((rel & (blk - 32'd1)) == 32'd0);
    fifo_empty = (free_count[cls] == '0);
    fifo_full  = (free_count[cls] == CntW'(FREE_DEPTH));
    bump_sum   = {1'b0, bump_offset[cls]} + 28'(blk);
    bump_ok    = (bump_sum <= 28'(arena_sz));
    head_next  = (free_head[cls] == PtrW'(FREE_DEPTH - 1)) ? '0 : free_head[cls] + PtrW'(1);
    tail_next  = (free_tail[cls] == PtrW'(FREE_DEPTH - 1)) ? '0 : free_tail[cls] + PtrW'(1);
    mem_base   = MemAw'(MemAw'(cls) * MemAw'(FREE_DEPTH));
    mem_rd_addr = mem_base + MemAw'(free_head[cls]);
    mem_wr_addr = mem_base + MemAw'(free_tail[cls]);
    mem_rd_en  = (state == S_SCAN) && hit && is_alloc && !fifo_empty;
    mem_wr_en  = (state == S_SCAN) && hit && !is_alloc && aligned && !fifo_full;
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      free_store[mem_wr_addr] <= req.free_address;
    end
    if (mem_rd_en) begin
      mem_rd_data <= free_store[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      arena_base <= scba_pkg::ARENA_BASE_RESET;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        bump_offset[i] <= '0;
        free_head[i]   <= '0;
        free_tail[i]   <= '0;
        free_count[i]  <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        arena_base <= cfg_wr_data;
      end
      // The output beat leaves when taken; a new one is loaded only in S_FINISH.
      if ((state != S_FINISH) && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            start <= arena_base;
            cls   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            res.size_class <= cls_ext;
            if (is_alloc && !fifo_empty) begin
              // Pop the oldest freed block; its address arrives next cycle.
              res.status      <= scba_pkg::STS_OK;
              free_head[cls]  <= head_next;
              free_count[cls] <= free_count[cls] - CntW'(1);
              state           <= S_POP;
            end else begin
              state <= S_FINISH;
              if (is_alloc) begin
                if (bump_ok) begin
                  res.status        <= scba_pkg::STS_OK;
                  res.block_address <= start + 32'(bump_offset[cls]);
                  bump_offset[cls]  <= bump_sum[26:0];
                end else begin
                  res.status        <= scba_pkg::STS_OOM;
                  res.block_address <= 32'd0;
                end
              end else begin
                res.block_address <= 32'd0;
                if (!aligned) begin
                  res.status <= scba_pkg::STS_MISALIGNED;
                end else if (fifo_full) begin
                  res.status <= scba_pkg::STS_FULL;
                end else begin
                  res.status      <= scba_pkg::STS_OK;
                  free_tail[cls]  <= tail_next;
                  free_count[cls] <= free_count[cls] + CntW'(1);
                end
              end
            end
          end else if (last_cls) begin
            res.status        <= is_alloc ? scba_pkg::STS_TOO_LARGE : scba_pkg::STS_UNKNOWN;
            res.block_address <= 32'd0;
            res.size_class    <= '0;
            state             <= S_FINISH;
          end else begin
            start <= start + arena_sz;
            cls   <= cls + CidxW'(1);
          end
        end
        S_POP: begin
          res.block_address <= mem_rd_data;
          state             <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The fill level of a class never passes the FIFO depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (free_count[cls] <= CntW'(FREE_DEPTH)))
    else $error("free FIFO fill level beyond depth");

  // Bumping never runs past the end of the class arena.
  a_bump_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (28'(bump_offset[cls]) <= 28'(arena_sz)))
    else $error("bump offset beyond arena");

  // The store is never read and written in the same cycle.
  a_mem_excl: assert property (@(posedge clk) disable iff (rst)
    !(mem_rd_en && mem_wr_en))
    else $error("free store read and write together");

  // A pop cycle always follows a scan cycle that issued the store read.
  a_pop_order: assert property (@(posedge clk) disable iff (rst)
    mem_rd_en |=> (state == S_POP))
    else $error("pop data cycle missing after store read");

  // A finished result reaches the output register once it is free.
  a_finish: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && !out_valid) |=> (out_valid && (state == S_IDLE)))
    else $error("result not delivered to output register");

endmodule
